/* rtl/rnc_pkg.sv */
package rnc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENC_ERR,
        ST_ENC_STEP,
        ST_ENC_SECOND,
        ST_DEC_SCAN,
        ST_DEC_DONE
    } state_t;

    localparam logic       KIND_ENCODE  = 1'b0;
    localparam logic       KIND_DECODE  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    localparam logic [15:0] NUM_MAX     = 16'd3999;
    localparam logic [11:0] VALUE_MAX   = 12'd3999;
    localparam logic [3:0]  ENC_LAST    = 4'd12;
    localparam logic [1:0]  GRP_UNITS   = 2'd3;
    localparam logic [1:0]  GRP_THOU    = 2'd0;

    localparam logic [7:0] CH_NONE = 8'h00;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_X    = 8'h58;
    localparam logic [7:0] CH_V    = 8'h56;
    localparam logic [7:0] CH_I    = 8'h49;

    typedef struct packed {
        logic        sub;
        logic [11:0] a;
        logic [11:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [11:0] res;
        logic        ge;
    } alu_rsp_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] digit;
    } dig_step_t;

    function automatic logic [11:0] enc_val(input logic [3:0] idx);
        case (idx)
            4'd0:    return 12'd1000;
            4'd1:    return 12'd900;
            4'd2:    return 12'd500;
            4'd3:    return 12'd400;
            4'd4:    return 12'd100;
            4'd5:    return 12'd90;
            4'd6:    return 12'd50;
            4'd7:    return 12'd40;
            4'd8:    return 12'd10;
            4'd9:    return 12'd9;
            4'd10:   return 12'd5;
            4'd11:   return 12'd4;
            default: return 12'd1;
        endcase
    endfunction

    function automatic logic [7:0] enc_first(input logic [3:0] idx);
        case (idx)
            4'd0:    return CH_M;
            4'd1:    return CH_C;
            4'd2:    return CH_D;
            4'd3:    return CH_C;
            4'd4:    return CH_C;
            4'd5:    return CH_X;
            4'd6:    return CH_L;
            4'd7:    return CH_X;
            4'd8:    return CH_X;
            4'd9:    return CH_I;
            4'd10:   return CH_V;
            default: return CH_I;
        endcase
    endfunction

    function automatic logic [7:0] enc_second(input logic [3:0] idx);
        case (idx)
            4'd1:    return CH_M;
            4'd3:    return CH_D;
            4'd5:    return CH_C;
            4'd7:    return CH_L;
            4'd9:    return CH_X;
            4'd11:   return CH_V;
            default: return CH_NONE;
        endcase
    endfunction

    function automatic logic [7:0] grp_one(input logic [1:0] g);
        case (g)
            2'd0:    return CH_M;
            2'd1:    return CH_C;
            2'd2:    return CH_X;
            default: return CH_I;
        endcase
    endfunction

    function automatic logic [7:0] grp_five(input logic [1:0] g);
        case (g)
            2'd1:    return CH_D;
            2'd2:    return CH_L;
            2'd3:    return CH_V;
            default: return CH_NONE;
        endcase
    endfunction

    function automatic logic [7:0] grp_ten(input logic [1:0] g);
        case (g)
            2'd1:    return CH_M;
            2'd2:    return CH_C;
            2'd3:    return CH_X;
            default: return CH_NONE;
        endcase
    endfunction

    // digit transition for letter c in group g holding digit d
    function automatic dig_step_t next_digit(input logic [1:0] g, input logic [3:0] d,
                                             input logic [7:0] c);
        dig_step_t r;
        r.ok    = 1'b0;
        r.digit = 4'd0;
        if (c == grp_one(g)) begin
            if (d inside {4'd0, 4'd1, 4'd2, 4'd5, 4'd6, 4'd7}) begin
                r.ok    = 1'b1;
                r.digit = d + 4'd1;
            end
        end else if (grp_five(g) != CH_NONE && c == grp_five(g)) begin
            if (d == 4'd0) begin
                r.ok    = 1'b1;
                r.digit = 4'd5;
            end else if (d == 4'd1) begin
                r.ok    = 1'b1;
                r.digit = 4'd4;
            end
        end else if (grp_ten(g) != CH_NONE && c == grp_ten(g)) begin
            if (d == 4'd1) begin
                r.ok    = 1'b1;
                r.digit = 4'd9;
            end
        end
        return r;
    endfunction

    // step times place value of group g, modulo 4096
    function automatic logic [11:0] grp_delta(input logic [1:0] g, input logic [3:0] step);
        case (g)
            2'd0:    return 12'(step) * 12'd1000;
            2'd1:    return 12'(step) * 12'd100;
            2'd2:    return 12'(step) * 12'd10;
            default: return 12'(step);
        endcase
    endfunction

endpackage

/* rtl/roman_numeral_converter.sv */
// Encode: take the request, then step through the value table with the shared add/subtract unit,
// skipping a table entry or emitting a letter at each step; an out-of-range number gives a range error.
// Decode: take the letter, run the group scan (no scan once the numeral has failed), then a
// finish step. Any result waits while m_axis_tready is low.
// s_axis_tready is high only while the sequencer is idle.
// Reset (rst_n low, asynchronous) clears the decode state, the sequencer and m_axis_tvalid.
module roman_numeral_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // number_in[15:0], char_in[23:16]
    input  logic        s_axis_tuser,   // kind
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // char_out[7:0], value_out[19:8], zero[23:20]
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast    // last
);

    rnc_pkg::state_t   state_reg, state_next;
    logic [3:0]        idx_reg, idx_next;
    logic [11:0]       rem_reg, rem_next;
    logic [1:0]        phase_reg, phase_next;
    logic [3:0]        dig_reg [4];
    logic [11:0]       value_reg, value_next;
    logic              fail_reg, fail_next;
    logic [1:0]        g_reg, g_next;
    logic [7:0]        char_reg, char_next;
    logic              lastc_reg, lastc_next;
    logic              dig_we;
    logic [3:0]        dig_wdata;
    logic              dec_clear;

    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_char_reg, m_char_next;
    logic [11:0]       m_value_reg, m_value_next;
    logic [1:0]        m_status_reg, m_status_next;
    logic              m_last_reg, m_last_next;

    rnc_pkg::alu_req_t alu_req;
    rnc_pkg::alu_rsp_t alu_rsp;
    rnc_pkg::dig_step_t dstep;

    logic              s_fire;
    logic              can_emit;
    logic              num_bad;
    logic [3:0]        cur_dig;
    logic [3:0]        step;
    logic [7:0]        second_ch;
    logic              dec_good;

    rnc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign s_axis_tready = (state_reg == rnc_pkg::ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign can_emit      = !m_valid_reg || m_axis_tready;
    assign num_bad       = (s_axis_tdata[15:0] == 16'd0) || (s_axis_tdata[15:0] > rnc_pkg::NUM_MAX);
    assign cur_dig       = (g_reg == phase_reg) ? dig_reg[g_reg] : 4'd0;
    assign dstep         = rnc_pkg::next_digit(g_reg, cur_dig, char_reg);
    assign step          = dstep.digit - cur_dig;
    assign second_ch     = rnc_pkg::enc_second(idx_reg);
    assign dec_good      = !fail_reg && (value_reg != 12'd0) && (value_reg <= rnc_pkg::VALUE_MAX);

    always_comb
    begin
        alu_req.sub = 1'b1;
        alu_req.a   = rem_reg;
        alu_req.b   = rnc_pkg::enc_val(idx_reg);
        if (state_reg == rnc_pkg::ST_DEC_SCAN)
        begin
            alu_req.sub = 1'b0;
            alu_req.a   = value_reg;
            alu_req.b   = rnc_pkg::grp_delta(g_reg, step);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rnc_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_axis_tuser == rnc_pkg::KIND_DECODE)
                        state_next = fail_reg ? rnc_pkg::ST_DEC_DONE : rnc_pkg::ST_DEC_SCAN;
                    else
                        state_next = num_bad ? rnc_pkg::ST_ENC_ERR : rnc_pkg::ST_ENC_STEP;
                end
            end
            rnc_pkg::ST_ENC_ERR:
            begin
                if (can_emit)
                    state_next = rnc_pkg::ST_IDLE;
            end
            rnc_pkg::ST_ENC_STEP:
            begin
                if (alu_rsp.ge && can_emit)
                begin
                    if (second_ch != rnc_pkg::CH_NONE)
                        state_next = rnc_pkg::ST_ENC_SECOND;
                    else if (alu_rsp.res == 12'd0)
                        state_next = rnc_pkg::ST_IDLE;
                end
            end
            rnc_pkg::ST_ENC_SECOND:
            begin
                if (can_emit)
                    state_next = (rem_reg == 12'd0) ? rnc_pkg::ST_IDLE : rnc_pkg::ST_ENC_STEP;
            end
            rnc_pkg::ST_DEC_SCAN:
            begin
                if (dstep.ok || g_reg == rnc_pkg::GRP_UNITS)
                    state_next = rnc_pkg::ST_DEC_DONE;
            end
            rnc_pkg::ST_DEC_DONE:
            begin
                if (!lastc_reg || can_emit)
                    state_next = rnc_pkg::ST_IDLE;
            end
            default:
                state_next = rnc_pkg::ST_IDLE;
        endcase
    end

    // datapath and result register
    always_comb
    begin
        idx_next      = idx_reg;
        rem_next      = rem_reg;
        phase_next    = phase_reg;
        value_next    = value_reg;
        fail_next     = fail_reg;
        g_next        = g_reg;
        char_next     = char_reg;
        lastc_next    = lastc_reg;
        dig_we        = 1'b0;
        dig_wdata     = dstep.digit;
        dec_clear     = 1'b0;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_char_next   = m_char_reg;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        case (state_reg)
            rnc_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    char_next  = s_axis_tdata[23:16];
                    lastc_next = s_axis_tlast;
                    rem_next   = s_axis_tdata[11:0];
                    idx_next   = 4'd0;
                    g_next     = phase_reg;
                end
            end
            rnc_pkg::ST_ENC_ERR:
            begin
                if (can_emit)
                begin
                    m_valid_next  = 1'b1;
                    m_char_next   = rnc_pkg::CH_NONE;
                    m_value_next  = 12'd0;
                    m_status_next = rnc_pkg::STATUS_RANGE;
                    m_last_next   = 1'b1;
                end
            end
            rnc_pkg::ST_ENC_STEP:
            begin
                if (!alu_rsp.ge)
                begin
                    if (idx_reg != rnc_pkg::ENC_LAST)
                        idx_next = idx_reg + 4'd1;
                end
                else if (can_emit)
                begin
                    rem_next      = alu_rsp.res;
                    m_valid_next  = 1'b1;
                    m_char_next   = rnc_pkg::enc_first(idx_reg);
                    m_value_next  = 12'd0;
                    m_status_next = rnc_pkg::STATUS_OK;
                    m_last_next   = (alu_rsp.res == 12'd0) && (second_ch == rnc_pkg::CH_NONE);
                end
            end
            rnc_pkg::ST_ENC_SECOND:
            begin
                if (can_emit)
                begin
                    m_valid_next  = 1'b1;
                    m_char_next   = second_ch;
                    m_value_next  = 12'd0;
                    m_status_next = rnc_pkg::STATUS_OK;
                    m_last_next   = (rem_reg == 12'd0);
                end
            end
            rnc_pkg::ST_DEC_SCAN:
            begin
                if (dstep.ok)
                begin
                    dig_we     = 1'b1;
                    phase_next = g_reg;
                    value_next = alu_rsp.res;
                end
                else if (g_reg == rnc_pkg::GRP_UNITS)
                    fail_next = 1'b1;
                else
                    g_next = g_reg + 2'd1;
            end
            rnc_pkg::ST_DEC_DONE:
            begin
                if (lastc_reg && can_emit)
                begin
                    m_valid_next  = 1'b1;
                    m_char_next   = rnc_pkg::CH_NONE;
                    m_value_next  = dec_good ? value_reg : 12'd0;
                    m_status_next = dec_good ? rnc_pkg::STATUS_OK : rnc_pkg::STATUS_BAD;
                    m_last_next   = 1'b1;
                    dec_clear     = 1'b1;
                    phase_next    = rnc_pkg::GRP_THOU;
                    value_next    = 12'd0;
                    fail_next     = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rnc_pkg::ST_IDLE;
            phase_reg    <= rnc_pkg::GRP_THOU;
            value_reg    <= 12'd0;
            fail_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
                dig_reg[i] <= 4'd0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            value_reg    <= value_next;
            fail_reg     <= fail_next;
            m_valid_reg  <= m_valid_next;
            if (dec_clear)
            begin
                for (int i = 0; i < 4; i++)
                    dig_reg[i] <= 4'd0;
            end
            else if (dig_we)
                dig_reg[g_reg] <= dig_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        rem_reg      <= rem_next;
        g_reg        <= g_next;
        char_reg     <= char_next;
        lastc_reg    <= lastc_next;
        m_char_reg   <= m_char_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'd0, m_value_reg, m_char_reg};
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;

    a_scan_not_failed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rnc_pkg::ST_DEC_SCAN |-> !fail_reg)
        else $error("group scan entered with decode already failed");

    a_enc_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rnc_pkg::ST_ENC_STEP |-> rem_reg != 12'd0)
        else $error("encode step with nothing left");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != rnc_pkg::STATUS_OK
        |-> m_axis_tlast && m_axis_tdata == 24'd0)
        else $error("error result carries data or is not last");

endmodule

/* rtl/rnc_alu.sv */
module rnc_alu (
    input  rnc_pkg::alu_req_t req,
    output rnc_pkg::alu_rsp_t rsp
);

    logic [11:0] b_eff;
    logic [12:0] sum;

    assign b_eff   = req.sub ? ~req.b : req.b;
    assign sum     = {1'b0, req.a} + {1'b0, b_eff} + {12'd0, req.sub};
    assign rsp.res = sum[11:0];
    assign rsp.ge  = sum[12];

endmodule
